// File: rtl/core/i2crts_pkg.sv
package i2crts_pkg;

   localparam logic [7:0] ST_BUS_ERROR = 8'h00;
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;

   localparam logic RW_READ_BIT = 1'b1;

   localparam logic [1:0] CSR_DEVICE_ADDRESS   = 2'd0;
   localparam logic [1:0] CSR_REGISTER_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_TRANSFER_LENGTH  = 2'd2;
   localparam logic [1:0] CSR_READ_MODE        = 2'd3;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OUT_OK         = 3'd0,
      OUT_ADDR_NACK  = 3'd1,
      OUT_DATA_NACK  = 3'd2,
      OUT_ARB_LOST   = 3'd3,
      OUT_BUS_ERROR  = 3'd4,
      OUT_UNEXPECTED = 3'd5,
      OUT_TIMEOUT    = 3'd6
   } outcome_type;

   typedef enum logic [3:0] {
      CLS_BEGIN,
      CLS_TIMEOUT,
      CLS_SLA_W,
      CLS_REG,
      CLS_DATA_ACK,
      CLS_SLA_R,
      CLS_SLAR_ACK,
      CLS_RX_ACK,
      CLS_RX_NACK,
      CLS_ADDR_NACK,
      CLS_DATA_NACK,
      CLS_ARB_LOST,
      CLS_BUS_ERROR,
      CLS_UNEXPECTED
   } cls_type;

   typedef struct packed {
      logic       command;
      logic [7:0] status_code;
      logic       timeout_hit;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       request_start;
      logic       request_stop;
      logic       request_ack;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [7:0] byte_index;
      logic       done_res;
      logic [2:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] transfer_length;
      logic       read_mode;
   } cfg_type;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } evt_type;

endpackage

// File: rtl/core/i2crts_front.sv
module i2crts_front import i2crts_pkg::*; (
   input  req_type req_in,
   input  logic    read_mode,
   output evt_type evt_out
);

   cls_type cls;

   always_comb begin
      cls = CLS_UNEXPECTED;
      if (!req_in.command) begin
         cls = CLS_BEGIN;
      end else if (req_in.timeout_hit) begin
         cls = CLS_TIMEOUT;
      end else begin
         case (req_in.status_code)
            ST_START:     cls = CLS_SLA_W;
            ST_SLAW_ACK:  cls = CLS_REG;
            ST_DATA_ACK:  cls = CLS_DATA_ACK;
            ST_RESTART:   cls = read_mode ? CLS_SLA_R : CLS_UNEXPECTED;
            ST_SLAR_ACK:  cls = read_mode ? CLS_SLAR_ACK : CLS_UNEXPECTED;
            ST_RX_ACK:    cls = read_mode ? CLS_RX_ACK : CLS_UNEXPECTED;
            ST_RX_NACK:   cls = read_mode ? CLS_RX_NACK : CLS_UNEXPECTED;
            ST_SLAW_NACK: cls = CLS_ADDR_NACK;
            ST_DATA_NACK: cls = CLS_DATA_NACK;
            ST_ARB_LOST:  cls = CLS_ARB_LOST;
            ST_BUS_ERROR: cls = CLS_BUS_ERROR;
            default:      cls = CLS_UNEXPECTED;
         endcase
      end
   end

   assign evt_out.cls     = cls;
   assign evt_out.rx_byte = req_in.rx_byte;
   assign evt_out.tx_byte = req_in.tx_byte;

endmodule

// File: rtl/core/i2crts_queue.sv
module i2crts_queue import i2crts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  evt_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output evt_type head_data
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   evt_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count did not follow push");

endmodule

// File: rtl/core/i2crts_back.sv
module i2crts_back import i2crts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    evt_valid,
   input  evt_type evt,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [7:0] byte_counter_ff, byte_counter_in;
   logic       end_flag_ff, end_flag_in;
   logic       halted_ff, halted_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    rsp_in;
   logic       emit;
   logic       load;
   logic [7:0] cnt_inc;

   assign cnt_inc = byte_counter_ff + 8'd1;
   assign pop     = evt_valid && (!rsp_valid_ff || !rsp_stall);
   assign load    = pop && emit;

   always_comb begin
      rsp_in          = '0;
      emit            = 1'b1;
      byte_counter_in = byte_counter_ff;
      end_flag_in     = end_flag_ff;
      halted_in       = halted_ff;
      if (evt.cls == CLS_BEGIN) begin
         byte_counter_in      = '0;
         end_flag_in          = 1'b0;
         halted_in            = 1'b0;
         rsp_in.request_start = 1'b1;
      end else if (halted_ff) begin
         emit = 1'b0;
      end else begin
         case (evt.cls)
            CLS_TIMEOUT: begin
               rsp_in.done_res = 1'b1;
               rsp_in.outcome  = OUT_TIMEOUT;
            end
            CLS_SLA_W: begin
               rsp_in.send_byte  = {cfg.device_address, 1'b0};
               rsp_in.send_valid = 1'b1;
            end
            CLS_REG: begin
               rsp_in.send_byte  = cfg.register_address;
               rsp_in.send_valid = 1'b1;
            end
            CLS_DATA_ACK: begin
               if (cfg.read_mode) begin
                  if (cfg.transfer_length != 8'd0) begin
                     rsp_in.request_start = 1'b1;
                  end else begin
                     rsp_in.request_stop = 1'b1;
                     rsp_in.done_res     = 1'b1;
                  end
               end else if (byte_counter_ff < cfg.transfer_length) begin
                  rsp_in.send_byte  = evt.tx_byte;
                  rsp_in.send_valid = 1'b1;
                  rsp_in.byte_index = byte_counter_ff;
                  byte_counter_in   = cnt_inc;
               end else begin
                  rsp_in.request_stop = 1'b1;
                  rsp_in.done_res     = 1'b1;
               end
            end
            CLS_SLA_R: begin
               rsp_in.send_byte  = {cfg.device_address, RW_READ_BIT};
               rsp_in.send_valid = 1'b1;
            end
            CLS_SLAR_ACK: begin
               rsp_in.request_ack = (cfg.transfer_length > 8'd1);
            end
            CLS_RX_ACK: begin
               rsp_in.rx_valid    = 1'b1;
               rsp_in.rx_data     = evt.rx_byte;
               rsp_in.byte_index  = byte_counter_ff;
               byte_counter_in    = cnt_inc;
               // ack while the byte after the next one is still wanted
               rsp_in.request_ack = ({1'b0, cnt_inc} + 9'd1) < {1'b0, cfg.transfer_length};
            end
            CLS_RX_NACK: begin
               rsp_in.rx_valid     = 1'b1;
               rsp_in.rx_data      = evt.rx_byte;
               rsp_in.byte_index   = byte_counter_ff;
               byte_counter_in     = cnt_inc;
               rsp_in.request_stop = 1'b1;
               rsp_in.done_res     = 1'b1;
            end
            CLS_ADDR_NACK: begin
               rsp_in.request_stop = 1'b1;
               rsp_in.done_res     = 1'b1;
               rsp_in.outcome      = OUT_ADDR_NACK;
            end
            CLS_DATA_NACK: begin
               rsp_in.request_stop = 1'b1;
               rsp_in.done_res     = 1'b1;
               rsp_in.outcome      = OUT_DATA_NACK;
            end
            CLS_ARB_LOST: begin
               if (cfg.read_mode) begin
                  rsp_in.request_stop = 1'b1;
               end else begin
                  rsp_in.request_start = 1'b1;
                  rsp_in.request_ack   = 1'b1;
               end
               rsp_in.done_res = 1'b1;
               rsp_in.outcome  = OUT_ARB_LOST;
            end
            CLS_BUS_ERROR: begin
               rsp_in.request_stop = 1'b1;
               rsp_in.request_ack  = 1'b1;
               rsp_in.done_res     = 1'b1;
               rsp_in.outcome      = OUT_BUS_ERROR;
            end
            default: begin
               rsp_in.request_stop = 1'b1;
               rsp_in.done_res     = 1'b1;
               rsp_in.outcome      = OUT_UNEXPECTED;
               halted_in           = 1'b1;
            end
         endcase
         if (rsp_in.done_res) begin
            end_flag_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_counter_ff <= '0;
         end_flag_ff     <= 1'b0;
         halted_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            byte_counter_ff <= byte_counter_in;
            end_flag_ff     <= end_flag_in;
            halted_ff       <= halted_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_sets_end: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_in.done_res) |=> end_flag_ff)
      else $error("end flag not set after completion");

   a_unexpected_halts: assert property (@(posedge clock) disable iff (reset)
      (pop && !halted_ff && evt.cls == CLS_UNEXPECTED) |=> halted_ff)
      else $error("unexpected status did not halt");

   a_outcome_needs_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.outcome != OUT_OK) |-> rsp_data_ff.done_res)
      else $error("error outcome without completion");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (pop && halted_ff && evt.cls != CLS_BEGIN) |=> !rsp_valid_ff || $stable(rsp_data_ff))
      else $error("halted block produced a result");

endmodule

// File: rtl/core/i2c_master_register_transfer_sequencer.sv
// An accepted item is held in the queue, then its result is registered onto rsp_valid.
// Throughput: one item per cycle while rsp_stall is low; the classifier feeds a two-entry
// queue and the executor retires one queued item per cycle into the output register.
// Status items seen while halted are consumed and give no result.
// Reset (synchronous, active high) clears the queue, the byte counter, end and halt flags,
// the output valid and all configuration registers.
module i2c_master_register_transfer_sequencer import i2crts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type cfg_ff;
   evt_type front_evt;
   evt_type head_evt;
   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:   cfg_ff.device_address   <= csr_wdata[6:0];
            CSR_REGISTER_ADDRESS: cfg_ff.register_address <= csr_wdata;
            CSR_TRANSFER_LENGTH:  cfg_ff.transfer_length  <= csr_wdata;
            CSR_READ_MODE:        cfg_ff.read_mode        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   i2crts_front u_front (
      .req_in    (req_data),
      .read_mode (cfg_ff.read_mode),
      .evt_out   (front_evt)
   );

   i2crts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (front_evt),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (head_evt)
   );

   i2crts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt_valid (q_head_valid),
      .evt       (head_evt),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: test/tb_top.sv
module tb_top;
   import i2crts_pkg::*;

   localparam logic       CMD_BEGIN   = 1'b0;
   localparam logic       CMD_STATUS  = 1'b1;
   localparam logic [7:0] ST_UNLISTED = 8'hFF;
   localparam int         CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic       csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   i2c_master_register_transfer_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   req_type pending_events[$];
   rsp_type expected_actions[$];
   cfg_type cfg_now = '0;
   logic [7:0] xfer_count = '0;
   logic       xfer_ended = 1'b0;
   logic       xfer_halted = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap_pct = 0;
   int  stall_pct = 0;
   int  mismatches = 0;
   int  cycle_count = 0;

   // action the sequencer should take for one item; returns 0 when it stays silent
   function automatic bit sequence_action(input req_type ev, output rsp_type act);
      logic       rd;
      logic [7:0] len;
      act = '0;
      rd  = cfg_now.read_mode;
      len = cfg_now.transfer_length;
      if (ev.command == CMD_BEGIN) begin
         xfer_count = '0;
         xfer_ended = 1'b0;
         xfer_halted = 1'b0;
         act.request_start = 1'b1;
         return 1'b1;
      end
      if (xfer_halted)
         return 1'b0;
      if (ev.timeout_hit) begin
         act.done_res = 1'b1;
         act.outcome = OUT_TIMEOUT;
      end else if (ev.status_code == ST_START) begin
         act.send_byte = {cfg_now.device_address, 1'b0};
         act.send_valid = 1'b1;
      end else if (ev.status_code == ST_SLAW_ACK) begin
         act.send_byte = cfg_now.register_address;
         act.send_valid = 1'b1;
      end else if (ev.status_code == ST_DATA_ACK) begin
         if (rd && len != 0) begin
            act.request_start = 1'b1;
         end else if (!rd && xfer_count < len) begin
            act.send_byte = ev.tx_byte;
            act.send_valid = 1'b1;
            act.byte_index = xfer_count;
            xfer_count = xfer_count + 8'd1;
         end else begin
            act.request_stop = 1'b1;
            act.done_res = 1'b1;
         end
      end else if (rd && ev.status_code == ST_RESTART) begin
         act.send_byte = {cfg_now.device_address, RW_READ_BIT};
         act.send_valid = 1'b1;
      end else if (rd && ev.status_code == ST_SLAR_ACK) begin
         act.request_ack = (len > 8'd1);
      end else if (rd && (ev.status_code == ST_RX_ACK || ev.status_code == ST_RX_NACK)) begin
         act.rx_valid = 1'b1;
         act.rx_data = ev.rx_byte;
         act.byte_index = xfer_count;
         xfer_count = xfer_count + 8'd1;
         if (ev.status_code == ST_RX_ACK) begin
            // ack while at least one more byte follows this next one
            act.request_ack = ({1'b0, xfer_count} + 9'd1 < {1'b0, len});
         end else begin
            act.request_stop = 1'b1;
            act.done_res = 1'b1;
         end
      end else if (ev.status_code == ST_SLAW_NACK) begin
         act.request_stop = 1'b1;
         act.done_res = 1'b1;
         act.outcome = OUT_ADDR_NACK;
      end else if (ev.status_code == ST_DATA_NACK) begin
         act.request_stop = 1'b1;
         act.done_res = 1'b1;
         act.outcome = OUT_DATA_NACK;
      end else if (ev.status_code == ST_ARB_LOST) begin
         if (rd) begin
            act.request_stop = 1'b1;
         end else begin
            act.request_start = 1'b1;
            act.request_ack = 1'b1;
         end
         act.done_res = 1'b1;
         act.outcome = OUT_ARB_LOST;
      end else if (ev.status_code == ST_BUS_ERROR) begin
         act.request_stop = 1'b1;
         act.request_ack = 1'b1;
         act.done_res = 1'b1;
         act.outcome = OUT_BUS_ERROR;
      end else begin
         act.request_stop = 1'b1;
         act.done_res = 1'b1;
         act.outcome = OUT_UNEXPECTED;
         xfer_halted = 1'b1;
      end
      if (act.done_res)
         xfer_ended = 1'b1;
      return 1'b1;
   endfunction

   task automatic check_field(input string what, input logic [7:0] want_v, got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %h actual %h", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   // driver: hold an item until it is taken, then maybe gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_events.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // monitor: predict on acceptance, compare each accepted result
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken && sequence_action(req_data, want))
         expected_actions.push_back(want);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            $display("%0t: unexpected result expected none actual %p", $time, rsp_data);
            mismatches++;
         end else begin
            want = expected_actions.pop_front();
            check_field("send_byte", want.send_byte, rsp_data.send_byte);
            check_field("send_valid", 8'(want.send_valid), 8'(rsp_data.send_valid));
            check_field("request_start", 8'(want.request_start),
                        8'(rsp_data.request_start));
            check_field("request_stop", 8'(want.request_stop), 8'(rsp_data.request_stop));
            check_field("request_ack", 8'(want.request_ack), 8'(rsp_data.request_ack));
            check_field("rx_valid", 8'(want.rx_valid), 8'(rsp_data.rx_valid));
            check_field("rx_data", want.rx_data, rsp_data.rx_data);
            check_field("byte_index", want.byte_index, rsp_data.byte_index);
            check_field("done_res", 8'(want.done_res), 8'(rsp_data.done_res));
            check_field("outcome", 8'(want.outcome), 8'(rsp_data.outcome));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_event(input logic cmd, input logic [7:0] status, input logic tmo,
                             input logic [7:0] rxb, txb);
      req_type ev;
      ev.command = cmd;
      ev.status_code = status;
      ev.timeout_hit = tmo;
      ev.rx_byte = rxb;
      ev.tx_byte = txb;
      pending_events.push_back(ev);
   endtask

   // calm counts quiet negedges in a row, which guards against the driver popping the last item
   task automatic wait_drained();
      int calm;
      calm = 0;
      while (calm < 2) begin
         @(negedge clock);
         if (pending_events.size() == 0 && (!req_valid || req_taken)
             && expected_actions.size() == 0)
            calm++;
         else
            calm = 0;
      end
      // halted items give no result and may still be in the pipe
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_config(input logic [6:0] dev, input logic [7:0] regv, len,
                             input logic rd);
      write_reg(CSR_DEVICE_ADDRESS, {1'b0, dev});
      write_reg(CSR_REGISTER_ADDRESS, regv);
      write_reg(CSR_TRANSFER_LENGTH, len);
      write_reg(CSR_READ_MODE, {7'd0, rd});
      cfg_now.device_address = dev;
      cfg_now.register_address = regv;
      cfg_now.transfer_length = len;
      cfg_now.read_mode = rd;
   endtask

   // one transfer as the engine would report it, with occasional faults when not clean
   task automatic add_transfer(input bit clean);
      logic [7:0] flow[$];
      logic [7:0] code;
      int  k, r;
      bit  cut;
      flow.push_back(ST_START);
      flow.push_back(ST_SLAW_ACK);
      flow.push_back(ST_DATA_ACK);
      if (!cfg_now.read_mode) begin
         for (k = 0; k < cfg_now.transfer_length; k++)
            flow.push_back(ST_DATA_ACK);
      end else if (cfg_now.transfer_length != 0) begin
         flow.push_back(ST_RESTART);
         flow.push_back(ST_SLAR_ACK);
         for (k = 1; k < cfg_now.transfer_length; k++)
            flow.push_back(ST_RX_ACK);
         flow.push_back(ST_RX_NACK);
      end
      push_event(CMD_BEGIN, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      cut = 1'b0;
      for (k = 0; k < flow.size() && !cut; k++) begin
         r = clean ? 99 : $urandom_range(99);
         if (r < 3) begin
            push_event(CMD_STATUS, flow[k], 1'b1, 8'($urandom_range(255)),
                       8'($urandom_range(255)));
            cut = 1'b1;
         end else if (r < 6) begin
            case ($urandom_range(3))
               0: code = ST_SLAW_NACK;
               1: code = ST_DATA_NACK;
               2: code = ST_ARB_LOST;
               default: code = ST_BUS_ERROR;
            endcase
            push_event(CMD_STATUS, code, 1'b0, 8'($urandom_range(255)),
                       8'($urandom_range(255)));
            cut = 1'b1;
         end else if (r < 9) begin
            push_event(CMD_STATUS, 8'($urandom_range(255)), 1'b0,
                       8'($urandom_range(255)), 8'($urandom_range(255)));
         end else begin
            push_event(CMD_STATUS, flow[k], 1'b0, 8'($urandom_range(255)),
                       8'($urandom_range(255)));
         end
      end
      // stray event once the transfer is over
      if (!clean && $urandom_range(7) == 0)
         push_event(CMD_STATUS, flow[$urandom_range(flow.size() - 1)], 1'b0,
                    8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   initial begin
      int p;
      logic [6:0] dev;
      logic [7:0] regv, len;
      logic       rd;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 35;
      stall_pct = 59;

      // write mode: full transfer, every fault code, timeout, halt and restart
      set_config(7'h7F, 8'hA5, 8'd1, 1'b0);
      push_event(CMD_BEGIN, 8'h00, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_START, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_SLAW_ACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_DATA_ACK, 1'b0, 8'h00, 8'hFF);
      push_event(CMD_STATUS, ST_DATA_ACK, 1'b0, 8'hFF, 8'h00);
      push_event(CMD_STATUS, ST_SLAW_NACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_DATA_NACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_ARB_LOST, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_BUS_ERROR, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_START, 1'b1, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_RX_ACK, 1'b0, 8'hFF, 8'hFF);
      push_event(CMD_STATUS, ST_START, 1'b0, 8'h00, 8'h00);
      push_event(CMD_BEGIN, 8'hFF, 1'b1, 8'hFF, 8'hFF);
      wait_drained();

      // read mode with repeated start
      set_config(7'h00, 8'h00, 8'd2, 1'b1);
      push_event(CMD_BEGIN, 8'h00, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_START, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_SLAW_ACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_DATA_ACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_RESTART, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_SLAR_ACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_RX_ACK, 1'b0, 8'hFF, 8'h00);
      push_event(CMD_STATUS, ST_RX_NACK, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_ARB_LOST, 1'b0, 8'h00, 8'h00);
      push_event(CMD_STATUS, ST_UNLISTED, 1'b0, 8'h00, 8'h00);
      wait_drained();

      for (p = 0; p < 12; p++) begin
         if (p < 4) begin
            send_gap_pct = 35;
            stall_pct = 59;
         end else if (p < 8) begin
            send_gap_pct = 59;
            stall_pct = 35;
         end else begin
            send_gap_pct = 0;
            stall_pct = 0;
         end
         dev  = (p == 0) ? 7'h00 : (p == 1) ? 7'h7F : 7'($urandom_range(127));
         regv = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(255));
         rd   = p[0];
         case (p)
            2, 3:    len = 8'd0;
            4, 9:    len = 8'd1;
            5:       len = 8'd255;
            default: len = 8'($urandom_range(8));
         endcase
         set_config(dev, regv, len, rd);
         if (len == 8'd255) begin
            // longest read, then extra bytes so the counter wraps
            add_transfer(1'b1);
            repeat (3)
               push_event(CMD_STATUS, ST_RX_ACK, 1'b0, 8'($urandom_range(255)),
                          8'($urandom_range(255)));
            wait_drained();
         end else begin
            // sender holds off until every result is back, halfway through
            repeat (2) begin
               while (pending_events.size() < 24) begin
                  if ($urandom_range(9) == 0)
                     push_event(1'($urandom_range(1)), 8'($urandom_range(255)),
                                1'($urandom_range(1)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
                  else
                     add_transfer(1'b0);
               end
               wait_drained();
            end
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
